>>> design/countdown_delay_slot_pool_defines.svh
// Assertion macros used by the countdown delay slot pool controller.
`ifndef COUNTDOWN_DELAY_SLOT_POOL_DEFINES_SVH
`define COUNTDOWN_DELAY_SLOT_POOL_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and disabled during rst.
`define CDSP_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("cdsp: same-cycle check failed");
// Next-cycle implication, sampled on clk and disabled during rst.
`define CDSP_ASSERT_NXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("cdsp: next-cycle check failed");
`else
`define CDSP_ASSERT_IMP(label, cond, prop)
`define CDSP_ASSERT_NXT(label, cond, prop)
`endif
`endif

>>> design/cdsp_pkg.sv
// Types and constants shared by the countdown delay slot pool modules.
`default_nettype none

package cdsp_pkg;

  // Fixed field widths of the command and result beats.
  localparam int OPC_W  = 3;
  localparam int BANK_W = 2;
  localparam int SLOT_W = 4;
  localparam int TICK_W = 16;

  // Command opcodes.
  localparam logic [OPC_W-1:0] OP_ALLOC   = 3'd0;
  localparam logic [OPC_W-1:0] OP_QUERY   = 3'd1;
  localparam logic [OPC_W-1:0] OP_RELEASE = 3'd2;
  localparam logic [OPC_W-1:0] OP_RESTART = 3'd3;
  localparam logic [OPC_W-1:0] OP_TICK    = 3'd4;
  localparam logic [OPC_W-1:0] OP_CLEAR   = 3'd5;

  // Result selection codes.
  localparam logic [1:0] RES_NONE  = 2'd0;
  localparam logic [1:0] RES_FULL  = 2'd1;
  localparam logic [1:0] RES_GRANT = 2'd2;
  localparam logic [1:0] RES_QUERY = 2'd3;

  // One slot as held in the slot memory.
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [TICK_W-1:0] ticks;
  } cdsp_entry_t;

  localparam int ENTRY_W = $bits(cdsp_entry_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       walk_rst;
    logic       scan;
    logic       qread;
    logic       wr_slot;
    logic       clr_step;
    logic       init_step;
    logic       res_set;
    logic [1:0] res_sel;
    logic       out_load;
  } cdsp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [OPC_W-1:0] op;
    logic             bank_ok;
    logic             slot_ok;
    logic             entry_free;
    logic             ev_last;
    logic             clr_last;
    logic             init_last;
    logic             out_free;
  } cdsp_sts_t;

endpackage

`default_nettype wire

>>> design/countdown_delay_slot_pool.sv
// Top level of the countdown delay slot pool.
//
//   channel | direction | handshake           | beat fields
//   --------+-----------+---------------------+-------------------------------------
//   in      | to pool   | in_valid / in_stall | opcode, bank, slot, delay_ticks
//   out     | from pool | out_valid/out_stall | status, granted_slot, expired
//
// One command is worked on at a time. Allocate and tick walk the bank
// through the slot memory one slot per cycle.
// After reset a clearing pass writes every one of the BANKS * SLOTS memory entries,
// one per cycle, and in_stall stays high throughout.
// A new command is taken while a finished result waits in the output register.
`default_nettype none

module countdown_delay_slot_pool import cdsp_pkg::*; #(
  parameter int SLOTS = 16,
  parameter int BANKS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [OPC_W-1:0]  opcode,
  input  wire logic [BANK_W-1:0] bank,
  input  wire logic [SLOT_W-1:0] slot,
  input  wire logic [TICK_W-1:0] delay_ticks,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   status,
  output logic [SLOT_W-1:0]      granted_slot,
  output logic                   expired
);

  cdsp_cmd_t cmd;
  cdsp_sts_t sts;

  cdsp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  cdsp_dp #(
    .SLOTS (SLOTS),
    .BANKS (BANKS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .opcode       (opcode),
    .bank         (bank),
    .slot         (slot),
    .delay_ticks  (delay_ticks),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .status       (status),
    .granted_slot (granted_slot),
    .expired      (expired)
  );

endmodule

`default_nettype wire

>>> design/cdsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module cdsp_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/cdsp_dp.sv
// Datapath of the slot pool: command registers, slot memory, walk counter and result.
`default_nettype none

module cdsp_dp import cdsp_pkg::*; #(
  parameter int SLOTS = 16,
  parameter int BANKS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cdsp_cmd_t         cmd,
  output cdsp_sts_t              sts,
  input  wire logic [OPC_W-1:0]  opcode,
  input  wire logic [BANK_W-1:0] bank,
  input  wire logic [SLOT_W-1:0] slot,
  input  wire logic [TICK_W-1:0] delay_ticks,
  input  wire logic              out_stall,
  output logic                   out_valid,
  output logic                   status,
  output logic [SLOT_W-1:0]      granted_slot,
  output logic                   expired
);

  localparam int ENTRIES = BANKS * SLOTS;
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int GW      = (AW > SLOT_W) ? AW : SLOT_W;

  // Registered command beat.
  logic [OPC_W-1:0]  op_r;
  logic              bank_ok_r;
  logic              slot_ok_r;
  logic [AW-1:0]     base_r;
  logic [AW-1:0]     saddr_r;
  logic [TICK_W-1:0] ticks_r;
  logic [AW-1:0]     base_in;

  // Walk state.
  logic [AW-1:0]     cnt;
  logic [AW-1:0]     ev_idx;
  logic              pend;
  logic              rd_done;

  // Memory ports.
  logic              we;
  logic [AW-1:0]     waddr;
  cdsp_entry_t       wentry;
  logic              re;
  logic [AW-1:0]     raddr;
  logic [ENTRY_W-1:0] rdata;
  cdsp_entry_t       rentry;
  cdsp_entry_t       tick_entry;

  // Pending result.
  logic              res_status;
  logic [SLOT_W-1:0] res_granted;
  logic              res_expired;
  logic [GW-1:0]     ev_ext;

  assign base_in = AW'(bank) * AW'(SLOTS);
  assign rentry  = rdata;
  assign ev_ext  = GW'(ev_idx);

  // Capture the command beat at acceptance.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= opcode;
      bank_ok_r <= 32'(bank) < 32'(BANKS);
      slot_ok_r <= 32'(slot) < 32'(SLOTS);
      base_r    <= base_in;
      saddr_r   <= base_in + AW'(slot);
      ticks_r   <= delay_ticks;
    end
  end

  // Walk counter, shared by the reset clearing pass, bank walks and bank clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      pend    <= 1'b0;
      rd_done <= 1'b0;
    end else if (cmd.walk_rst) begin
      cnt     <= '0;
      pend    <= 1'b0;
      rd_done <= 1'b0;
    end else if (cmd.init_step || cmd.clr_step) begin
      cnt <= cnt + 1'b1;
    end else if (cmd.scan) begin
      pend <= !rd_done;
      if (!rd_done) begin
        cnt     <= cnt + 1'b1;
        rd_done <= cnt == AW'(SLOTS - 1);
      end
    end
  end

  // Index of the slot whose data comes out of the memory next cycle.
  always_ff @(posedge clk) begin
    if (cmd.scan && !rd_done) begin
      ev_idx <= cnt;
    end
  end

  // Tick update of one slot: count down, then flag done at zero.
  always_comb begin
    tick_entry = rentry;
    if (rentry.busy && rentry.ticks != '0) begin
      tick_entry.ticks = rentry.ticks - 16'd1;
    end
    if (rentry.busy && tick_entry.ticks == '0) begin
      tick_entry.done = 1'b1;
    end
  end

  // Memory read port selection.
  always_comb begin
    re    = 1'b0;
    raddr = base_r + cnt;
    if (cmd.qread) begin
      re    = 1'b1;
      raddr = saddr_r;
    end else if (cmd.scan && !rd_done) begin
      re = 1'b1;
    end
  end

  // Memory write port selection.
  always_comb begin
    we     = 1'b0;
    waddr  = base_r + cnt;
    wentry = '0;
    if (cmd.init_step) begin
      we    = 1'b1;
      waddr = cnt;
    end else if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.wr_slot) begin
      we    = 1'b1;
      waddr = saddr_r;
      if (op_r == OP_RESTART) begin
        wentry.busy  = 1'b1;
        wentry.ticks = ticks_r;
      end
    end else if (cmd.scan && pend) begin
      waddr = base_r + ev_idx;
      if (op_r == OP_TICK) begin
        we     = 1'b1;
        wentry = tick_entry;
      end else if (!rentry.busy) begin
        we           = 1'b1;
        wentry.busy  = 1'b1;
        wentry.ticks = ticks_r;
      end
    end
  end

  cdsp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (ENTRIES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Pending result, held until the output register is free.
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_status  <= 1'b0;
      res_granted <= '0;
      res_expired <= 1'b0;
      case (cmd.res_sel)
        RES_FULL:  res_status  <= 1'b1;
        RES_GRANT: res_granted <= ev_ext[SLOT_W-1:0];
        RES_QUERY: res_expired <= rentry.done;
        default: begin
        end
      endcase
    end
  end

  // Output register for the result beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status       <= res_status;
      granted_slot <= res_granted;
      expired      <= res_expired;
    end
  end

  // Status towards the controller.
  always_comb begin
    sts            = '0;
    sts.op         = op_r;
    sts.bank_ok    = bank_ok_r;
    sts.slot_ok    = slot_ok_r;
    sts.entry_free = pend && !rentry.busy;
    sts.ev_last    = pend && (ev_idx == AW'(SLOTS - 1));
    sts.clr_last   = cnt == AW'(SLOTS - 1);
    sts.init_last  = cnt == AW'(ENTRIES - 1);
    sts.out_free   = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire

>>> design/cdsp_ctrl.sv
// Controller state machine of the slot pool.
`default_nettype none
`include "countdown_delay_slot_pool_defines.svh"

module cdsp_ctrl import cdsp_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire cdsp_sts_t sts,
  output cdsp_cmd_t      cmd
);

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DECODE = 3'd2;
  localparam logic [2:0] ST_SCAN   = 3'd3;
  localparam logic [2:0] ST_QWAIT  = 3'd4;
  localparam logic [2:0] ST_CLEAR  = 3'd5;
  localparam logic [2:0] ST_RESP   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      ST_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load     = 1'b1;
          cmd.walk_rst = 1'b1;
          state_next   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cmd.res_set = 1'b1;
        cmd.res_sel = RES_NONE;
        state_next  = ST_RESP;
        case (sts.op)
          OP_ALLOC: begin
            if (sts.bank_ok) begin
              cmd.res_set = 1'b0;
              state_next  = ST_SCAN;
            end else begin
              cmd.res_sel = RES_FULL;
            end
          end
          OP_QUERY: begin
            if (sts.bank_ok && sts.slot_ok) begin
              cmd.res_set = 1'b0;
              cmd.qread   = 1'b1;
              state_next  = ST_QWAIT;
            end
          end
          OP_RELEASE, OP_RESTART: begin
            cmd.wr_slot = sts.bank_ok && sts.slot_ok;
          end
          OP_TICK: begin
            if (sts.bank_ok) begin
              cmd.res_set = 1'b0;
              state_next  = ST_SCAN;
            end
          end
          OP_CLEAR: begin
            if (sts.bank_ok) begin
              cmd.res_set = 1'b0;
              state_next  = ST_CLEAR;
            end
          end
          default: begin
          end
        endcase
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.op == OP_ALLOC && sts.entry_free) begin
          cmd.res_set = 1'b1;
          cmd.res_sel = RES_GRANT;
          state_next  = ST_RESP;
        end else if (sts.ev_last) begin
          cmd.res_set = 1'b1;
          cmd.res_sel = (sts.op == OP_ALLOC) ? RES_FULL : RES_NONE;
          state_next  = ST_RESP;
        end
      end
      ST_QWAIT: begin
        cmd.res_set = 1'b1;
        cmd.res_sel = RES_QUERY;
        state_next  = ST_RESP;
      end
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          cmd.res_set = 1'b1;
          cmd.res_sel = RES_NONE;
          state_next  = ST_RESP;
        end
      end
      ST_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  // A bank walk only runs for allocate and tick.
  `CDSP_ASSERT_IMP(a_scan_op, state == ST_SCAN, sts.op == OP_ALLOC || sts.op == OP_TICK)
  // A slot read for query only happens on a slot inside the pool.
  `CDSP_ASSERT_IMP(a_query_ok, state == ST_QWAIT, sts.bank_ok && sts.slot_ok)
  // Bank clear only sweeps an existing bank.
  `CDSP_ASSERT_IMP(a_clear_ok, state == ST_CLEAR, sts.bank_ok)
  // Once the result is handed over the block is ready for the next beat.
  `CDSP_ASSERT_NXT(a_resp_done, state == ST_RESP && sts.out_free, state == ST_IDLE)

endmodule

`default_nettype wire
